// ----- hw/rtl/sha1mh_pkg.sv -----
package sha1mh_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 5;
    localparam int BLOCK_W    = 512;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 64;
    localparam int ROUND_W    = 7;
    localparam int IDX_W      = 3;
    localparam int NUM_ROUNDS = 80;

    localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
    localparam logic [POS_W-1:0]   POS_LENGTH = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST   = 3'(NUM_WORDS - 1);
    localparam logic [7:0]         PAD_MARK   = 8'h80;
    localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 64'd8;

    localparam logic [WORD_W-1:0] H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [IDX_W-1:0]  word_index;
        logic              last_word;
    } digest_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_LO,
        PH_MAJORITY,
        PH_PARITY_HI
    } rnd_phase_t;

    typedef struct packed {
        logic       step;
        rnd_phase_t phase;
        logic       finish;
        logic       rotate;
        logic       reinit;
    } rnd_ctl_t;

    function automatic logic [WORD_W-1:0] sha1mh_f(
        input rnd_phase_t        ph,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] res;
        unique case (ph)
            PH_CHOOSE:   res = (b & c) | (~b & d);
            PH_MAJORITY: res = (b & c) | (b & d) | (c & d);
            default:     res = b ^ c ^ d;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] sha1mh_k(input rnd_phase_t ph);
        logic [WORD_W-1:0] res;
        unique case (ph)
            PH_CHOOSE:    res = 32'h5A827999;
            PH_PARITY_LO: res = 32'h6ED9EBA1;
            PH_MAJORITY:  res = 32'h8F1BBCDC;
            default:      res = 32'hCA62C1D6;
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/sha1_message_hasher.sv -----
// a transaction carrying a byte is taken while idle; the 64th byte of a block
// starts the 80 rounds of the single round unit, followed by the chaining add
// end of message: padding bytes at one a cycle, one or two compressions,
// then five digest words, one a cycle when not stalled
// new message transactions are stalled while a block is compressed or padded and while the digest is out
// reset (asynchronous, active low) restores the initial chaining words and empties the message
module sha1_message_hasher
    import sha1mh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_item_t    msg,
    output logic         digest_valid,
    input  logic         digest_stall,
    output digest_item_t digest
);

    seq_state_t           state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pad_reg, pad_next;
    logic                 mark_reg, mark_next;
    logic                 len_reg, len_next;

    logic                 msg_take;
    logic                 digest_take;
    logic                 load_en;
    logic [7:0]           load_byte;
    logic [7:0]           pad_byte;
    logic                 len_byte;
    logic                 sched_en;
    rnd_ctl_t             ctl;
    logic [WORD_W-1:0]    sched_word;
    logic [WORD_W-1:0]    head_word;

    assign msg_take    = msg_valid && !msg_stall;
    assign digest_take = digest_valid && !digest_stall;

    assign len_byte = mark_reg && (len_reg || pos_reg == POS_LENGTH);
    assign pad_byte = !mark_reg ? PAD_MARK : (len_byte ? count_reg[COUNT_W-1 -: 8] : 8'h00);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.carries_byte && pos_reg == POS_LAST)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (pad_reg)
                begin
                    state_next = len_reg ? ST_OUT : ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (pos_reg == POS_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (!digest_stall && idx_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        msg_stall    = 1'b1;
        digest_valid = 1'b0;
        load_en      = 1'b0;
        load_byte    = msg.data_byte;
        sched_en     = 1'b0;
        ctl          = '0;
        if (round_reg < 7'd20)
        begin
            ctl.phase = PH_CHOOSE;
        end
        else if (round_reg < 7'd40)
        begin
            ctl.phase = PH_PARITY_LO;
        end
        else if (round_reg < 7'd60)
        begin
            ctl.phase = PH_MAJORITY;
        end
        else
        begin
            ctl.phase = PH_PARITY_HI;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                msg_stall = 1'b0;
                load_en   = msg_valid && msg.carries_byte;
            end
            ST_ROUND:
            begin
                sched_en = 1'b1;
                ctl.step = 1'b1;
            end
            ST_FINAL:
            begin
                ctl.finish = 1'b1;
            end
            ST_PAD:
            begin
                load_en   = 1'b1;
                load_byte = pad_byte;
            end
            ST_OUT:
            begin
                digest_valid = 1'b1;
                ctl.rotate   = !digest_stall;
                ctl.reinit   = !digest_stall && idx_reg == IDX_LAST;
            end
            default:
            begin
                msg_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        round_next = '0;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        len_next   = len_reg;
        if (load_en)
        begin
            pos_next = pos_reg + 6'd1;
        end
        if (msg_take && msg.carries_byte)
        begin
            count_next = count_reg + BITS_PER_BYTE;
        end
        if (msg_take && msg.end_of_message)
        begin
            pad_next = 1'b1;
        end
        if (state_reg == ST_ROUND)
        begin
            round_next = round_reg + 7'd1;
        end
        if (state_reg == ST_PAD)
        begin
            mark_next = 1'b1;
            if (len_byte)
            begin
                len_next   = 1'b1;
                count_next = {count_reg[COUNT_W-9:0], 8'h00};
            end
        end
        if (digest_take)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (ctl.reinit)
        begin
            pos_next   = '0;
            count_next = '0;
            idx_next   = '0;
            pad_next   = 1'b0;
            mark_next  = 1'b0;
            len_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
        end
    end

    assign digest.digest_word = head_word;
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = idx_reg == IDX_LAST;

    sha1mh_msgbuf u_msgbuf (
        .clk        (clk),
        .load_en    (load_en),
        .load_byte  (load_byte),
        .sched_en   (sched_en),
        .sched_word (sched_word)
    );

    sha1mh_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sched_word (sched_word),
        .head_word  (head_word)
    );

endmodule

// ----- hw/rtl/sha1mh_msgbuf.sv -----
module sha1mh_msgbuf
    import sha1mh_pkg::*;
(
    input  logic              clk,
    input  logic              load_en,
    input  logic [7:0]        load_byte,
    input  logic              sched_en,
    output logic [WORD_W-1:0] sched_word
);

    logic [BLOCK_W-1:0] buf_reg;
    logic [BLOCK_W-1:0] buf_next;
    logic [WORD_W-1:0]  mix;
    logic [WORD_W-1:0]  new_word;

    // window holds w[t..t+15], word 0 at the top
    assign sched_word = buf_reg[BLOCK_W-1 -: WORD_W];
    assign mix = buf_reg[BLOCK_W-1-13*WORD_W -: WORD_W]
               ^ buf_reg[BLOCK_W-1-8*WORD_W -: WORD_W]
               ^ buf_reg[BLOCK_W-1-2*WORD_W -: WORD_W]
               ^ buf_reg[BLOCK_W-1 -: WORD_W];
    assign new_word = {mix[WORD_W-2:0], mix[WORD_W-1]};

    always_comb
    begin
        buf_next = buf_reg;
        if (load_en)
        begin
            buf_next = {buf_reg[BLOCK_W-9:0], load_byte};
        end
        else if (sched_en)
        begin
            buf_next = {buf_reg[BLOCK_W-WORD_W-1:0], new_word};
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ----- hw/rtl/sha1mh_round.sv -----
module sha1mh_round
    import sha1mh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rnd_ctl_t          ctl,
    input  logic [WORD_W-1:0] sched_word,
    output logic [WORD_W-1:0] head_word
);

    logic [WORD_W-1:0] h_reg [NUM_WORDS];
    logic [WORD_W-1:0] h_next [NUM_WORDS];
    logic [WORD_W-1:0] v_reg [NUM_WORDS];
    logic [WORD_W-1:0] v_next [NUM_WORDS];
    logic [WORD_W-1:0] t_sum;

    // working words a..e sit in v_reg[0..4]
    assign t_sum = {v_reg[0][WORD_W-6:0], v_reg[0][WORD_W-1 -: 5]}
                 + sha1mh_f(ctl.phase, v_reg[1], v_reg[2], v_reg[3])
                 + v_reg[4] + sha1mh_k(ctl.phase) + sched_word;

    assign head_word = h_reg[0];

    always_comb
    begin
        h_next = h_reg;
        v_next = v_reg;
        if (ctl.reinit)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                h_next[i] = H_INIT[i];
                v_next[i] = H_INIT[i];
            end
        end
        else if (ctl.step)
        begin
            v_next[0] = t_sum;
            v_next[1] = v_reg[0];
            v_next[2] = {v_reg[1][1:0], v_reg[1][WORD_W-1:2]};
            v_next[3] = v_reg[2];
            v_next[4] = v_reg[3];
        end
        else if (ctl.finish)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
                v_next[i] = h_reg[i] + v_reg[i];
            end
        end
        else if (ctl.rotate)
        begin
            for (int i = 0; i < NUM_WORDS - 1; i++)
            begin
                h_next[i] = h_reg[i+1];
            end
            h_next[NUM_WORDS-1] = h_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                h_reg[i] <= H_INIT[i];
                v_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            h_reg <= h_next;
            v_reg <= v_next;
        end
    end

endmodule

// ----- hw/rtl/sha1mh_checker.sv -----
module sha1mh_checker
    import sha1mh_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         msg_valid,
    input logic         msg_stall,
    input logic         digest_valid,
    input logic         digest_stall,
    input digest_item_t digest
);

    // stalled digest transaction holds
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest))
        else $error("digest changed while stalled");

    // no message transaction taken while the digest is out
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> !(msg_valid && !msg_stall))
        else $error("message taken during digest output");

    // last flag only on the final word
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == IDX_LAST)))
        else $error("last word flag mismatch");

    // words follow one another in order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !digest.last_word
        |=> digest_valid && digest.word_index == $past(digest.word_index) + 3'd1)
        else $error("digest word out of order");

    // nothing after the final word until a new message ends
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && digest.last_word |=> !digest_valid)
        else $error("digest output after final word");

endmodule

bind sha1_message_hasher sha1mh_checker u_checker (.*);

// ----- tb/sv/tb_sha1_message_hasher.sv -----
`timescale 1ns / 100ps

module tb_sha1_message_hasher;
    import sha1mh_pkg::*;

    localparam int QUIET_LIMIT    = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int NUM_DIRECTED   = 13;
    localparam int NUM_ITEMS      = 310;
    localparam int ITEM_MARGIN    = 8;
    localparam int NUM_BOUNDARY   = 4;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
    localparam logic [159:0] NO_DIGEST    = 160'h0;

    typedef struct packed {
        msg_item_t    item;
        logic         typed;
        logic [159:0] digest;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    msg_item_t    msg = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    digest_item_t digest;

    // hash state of the predictor
    logic [31:0] hash_words [5];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_pos;
    logic [63:0] bit_length;

    digest_item_t pending_words [$];

    int mismatches = 0;
    int words_checked = 0;
    int digests_checked = 0;
    int transactions_sent = 0;
    int burst_left = 0;
    int longest_message = 0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        {8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        {8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        {8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'hAA, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        {8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
        {8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        {8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        {8'h55, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        {8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
    };

    sha1_message_hasher u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_hash();
        hash_words[0] = 32'h67452301;
        hash_words[1] = 32'hEFCDAB89;
        hash_words[2] = 32'h98BADCFE;
        hash_words[3] = 32'h10325476;
        hash_words[4] = 32'hC3D2E1F0;
        fill_pos      = '0;
        bit_length    = '0;
    endfunction

    function automatic void compress_block_model();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int r = 0; r < 16; r++)
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        for (int r = 16; r < 80; r++)
        begin
            x = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
            sched[r] = {x[30:0], x[31]};
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        block_bytes[fill_pos] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0)
            compress_block_model();
    endfunction

    function automatic void predict_digest(input msg_item_t it, input logic typed,
                                           input logic [159:0] typed_digest);
        logic [63:0]  len;
        digest_item_t w;
        if (it.carries_byte)
        begin
            absorb_byte(it.data_byte);
            bit_length += 64'd8;
        end
        if (it.end_of_message)
        begin
            len = bit_length;
            absorb_byte(8'h80);
            while (fill_pos != 6'd56)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(len[63-8*i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                w.digest_word = typed ? typed_digest[159-32*i -: 32] : hash_words[i];
                w.word_index  = 3'(i);
                w.last_word   = (i == 4);
                pending_words.push_back(w);
            end
            restart_hash();
        end
    endfunction

    task automatic send_transaction(input msg_item_t it, input logic typed,
                                    input logic [159:0] typed_digest);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                msg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        msg       <= it;
        msg_valid <= 1'b1;
        do
            @(posedge clk);
        while (msg_stall);
        transactions_sent++;
        predict_digest(it, typed, typed_digest);
    endtask

    task automatic wait_for_digests();
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected digest word %h index %0d", digest.digest_word,
                       digest.word_index);
                mismatches++;
            end
            else
            begin
                if (digest.digest_word !== pending_words[0].digest_word)
                begin
                    $error("digest_word expected %h actual %h",
                           pending_words[0].digest_word, digest.digest_word);
                    mismatches++;
                end
                if (digest.word_index !== pending_words[0].word_index)
                begin
                    $error("word_index expected %0d actual %0d",
                           pending_words[0].word_index, digest.word_index);
                    mismatches++;
                end
                if (digest.last_word !== pending_words[0].last_word)
                begin
                    $error("last_word expected %0b actual %0b",
                           pending_words[0].last_word, digest.last_word);
                    mismatches++;
                end
                if (pending_words[0].last_word)
                    digests_checked++;
                void'(pending_words.pop_front());
            end
            words_checked++;
        end
    end

    // receiver stall pattern, with one long hold-off once digests are flowing
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                digest_stall <= 1'b1;
            end
            else if (!hold_done && words_checked >= 40 && digest_valid)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                digest_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       digest_stall <= 1'b0;
                    1:       digest_stall <= ($urandom_range(0, 3) == 0);
                    2:       digest_stall <= ($urandom_range(0, 3) != 0);
                    default: digest_stall <= ~digest_stall;
                endcase
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_sha1_message_hasher failed");
        $finish;
    end

    initial
    begin
        int        boundary_lengths [NUM_BOUNDARY];
        int        msg_count;
        int        len;
        bit        merge;
        msg_item_t it;
        boundary_lengths = '{55, 56, 63, 64};
        msg_count  = 0;
        restart_hash();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_transaction(directed_rows[i].item, directed_rows[i].typed,
                             directed_rows[i].digest);
        msg_valid <= 1'b0;
        wait_for_digests();

        while (transactions_sent < NUM_ITEMS - ITEM_MARGIN)
        begin
            if (msg_count < NUM_BOUNDARY)
                len = boundary_lengths[msg_count];
            else
                len = $urandom_range(0, 12);
            merge = 1'($urandom_range(0, 1));
            if (len > longest_message)
                longest_message = len;
            for (int b = 0; b < len; b++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    it.data_byte      = 8'($urandom_range(0, 255));
                    it.carries_byte   = 1'b0;
                    it.end_of_message = 1'b0;
                    send_transaction(it, 1'b0, NO_DIGEST);
                end
                it.data_byte      = 8'($urandom_range(0, 255));
                it.carries_byte   = 1'b1;
                it.end_of_message = merge && (b == len - 1);
                send_transaction(it, 1'b0, NO_DIGEST);
            end
            if (!(merge && len > 0))
            begin
                it.data_byte      = 8'($urandom_range(0, 255));
                it.carries_byte   = 1'b0;
                it.end_of_message = 1'b1;
                send_transaction(it, 1'b0, NO_DIGEST);
            end
            msg_count++;
            if (msg_count == NUM_BOUNDARY)
            begin
                msg_valid <= 1'b0;
                wait_for_digests();
            end
        end
        msg_valid <= 1'b0;
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent over %0d random messages, longest %0d bytes",
                 transactions_sent, msg_count, longest_message);
        $display("%0d digests (%0d words) compared, %0d mismatches",
                 digests_checked, words_checked, mismatches);
        if (mismatches == 0)
            $display("tb_sha1_message_hasher passed");
        else
            $display("tb_sha1_message_hasher failed");
        $finish;
    end

endmodule
